// File: hw/rtl/value_noise_1d_core_defines.svh
// Assertion macros shared by the noise core
`ifndef VALUE_NOISE_1D_CORE_DEFINES_SVH
`define VALUE_NOISE_1D_CORE_DEFINES_SVH

// clocked check, masked while reset is held
`define VN1D_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vn1d check failed");

// clocked check that also runs through reset
`define VN1D_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("vn1d check failed");

`endif

// File: hw/rtl/vn1d_pkg.sv
`default_nettype none
package vn1d_pkg;
    localparam int FRAC_BITS = 16;
    localparam int A_W       = 32 + FRAC_BITS;   // dividend magnitude width
    localparam int QD        = 4;                 // queue depth
    localparam int QP_W      = $clog2(QD);

    localparam logic [1:0] CFG_MIN_VALUE     = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE     = 2'd1;
    localparam logic [1:0] CFG_PERIOD_LENGTH = 2'd2;
    localparam logic [1:0] CFG_PHASE_OFFSET  = 2'd3;

    localparam logic [31:0] HASH_MUL  = 32'd15731;
    localparam logic [31:0] HASH_ADD  = 32'd789221;
    localparam logic [31:0] HASH_OFF  = 32'd1376312589;
    localparam logic [31:0] ONE30     = 32'h4000_0000;
    localparam logic [31:0] THREE30   = 32'hC000_0000;
    localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic        [30:0] period_length;
        logic signed [31:0] phase_offset;
    } t_cfg;

    typedef struct packed {
        logic           neg;
        logic [A_W-1:0] mag;   // |num| or |num|-1 when negative
    } t_div_req;

    typedef struct packed {
        logic           vld;
        logic           neg;
        logic [A_W-1:0] quo;
    } t_div_res;
endpackage
`default_nettype wire

// File: hw/rtl/value_noise_1d_core.sv
// Channel  | Signals                     | Word
// ---------+-----------------------------+-----------------------------------
// s_axis   | tvalid tready tdata[31:0]   | [31:0] position, signed Q16.16
// m_axis   | tvalid tready tdata[31:0]   | [31:0] noise_value, signed Q16.16
// cfg      | i_cfg_we i_cfg_idx i_cfg_data| register write, no read-back
//
// One word per cycle sustained while m_axis is ready; the result passes through
// the 48-stage restoring divider (one quotient bit per stage), then the shaper.
// The 4-entry queue takes input while the back end is stalled.
// Synchronous active-low reset clears valids and loads register defaults.
`default_nettype none
module value_noise_1d_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] position
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] noise_value
);
    vn1d_pkg::t_cfg     w_cfg;
    vn1d_pkg::t_div_req w_req_in, w_req_out;
    vn1d_pkg::t_div_res w_div;
    logic w_full, w_empty, w_push, w_pop, w_adv;

    assign s_axis_tready = !w_full;
    assign w_push = s_axis_tvalid && !w_full;
    assign w_adv  = !m_axis_tvalid || m_axis_tready;
    assign w_pop  = w_adv && !w_empty;

    vn1d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_position (s_axis_tdata),
        .o_cfg      (w_cfg),
        .o_req      (w_req_in)
    );

    vn1d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_req   (w_req_out)
    );

    vn1d_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_vld    (w_pop),
        .i_req    (w_req_out),
        .i_period (w_cfg.period_length),
        .o_res    (w_div)
    );

    vn1d_shape u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_res   (w_div),
        .i_cfg   (w_cfg),
        .o_vld   (m_axis_tvalid),
        .o_value (m_axis_tdata)
    );
endmodule
`default_nettype wire

// File: hw/rtl/vn1d_front.sv
`default_nettype none
module vn1d_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic [31:0]        i_position,
    output vn1d_pkg::t_cfg          o_cfg,
    output vn1d_pkg::t_div_req      o_req
);
    vn1d_pkg::t_cfg r_cfg;

    logic signed [32:0] s_sum;
    logic        [32:0] s_abs;
    logic        [vn1d_pkg::A_W:0] s_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value     <= '0;
            r_cfg.max_value     <= 32'sd1 <<< vn1d_pkg::FRAC_BITS;
            r_cfg.period_length <= 31'd1 << vn1d_pkg::FRAC_BITS;
            r_cfg.phase_offset  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vn1d_pkg::CFG_MIN_VALUE:     r_cfg.min_value     <= i_cfg_data;
                vn1d_pkg::CFG_MAX_VALUE:     r_cfg.max_value     <= i_cfg_data;
                vn1d_pkg::CFG_PERIOD_LENGTH: r_cfg.period_length <= i_cfg_data[30:0];
                vn1d_pkg::CFG_PHASE_OFFSET:  r_cfg.phase_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // floor division on magnitudes: negative numerators divide |num|-1, result is ~q
    always_comb begin
        s_sum = $signed({i_position[31], i_position}) +
                $signed({r_cfg.phase_offset[31], r_cfg.phase_offset});
        s_abs = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);
        s_num = {s_abs, {vn1d_pkg::FRAC_BITS{1'b0}}};
        o_req.neg = s_sum[32];
        o_req.mag = s_sum[32] ? vn1d_pkg::A_W'(s_num - 1'b1) : s_num[vn1d_pkg::A_W-1:0];
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: hw/rtl/vn1d_queue.sv
`default_nettype none
`include "value_noise_1d_core_defines.svh"
module vn1d_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  vn1d_pkg::t_div_req      i_req,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output vn1d_pkg::t_div_req      o_req
);
    vn1d_pkg::t_div_req            r_mem [vn1d_pkg::QD];
    logic [vn1d_pkg::QP_W-1:0]     r_wp, r_rp;
    logic [vn1d_pkg::QP_W:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + (vn1d_pkg::QP_W+1)'(i_push) - (vn1d_pkg::QP_W+1)'(i_pop);
        end
    end

    assign o_full  = (r_count == (vn1d_pkg::QP_W+1)'(vn1d_pkg::QD));
    assign o_empty = (r_count == '0);
    assign o_req   = r_mem[r_rp];

    `VN1D_ASSERT(a_q_bound, r_count <= (vn1d_pkg::QP_W+1)'(vn1d_pkg::QD))
    `VN1D_ASSERT(a_q_no_underrun, i_pop |-> !o_empty)
    `VN1D_ASSERT(a_q_fill, (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
endmodule
`default_nettype wire

// File: hw/rtl/vn1d_div.sv
`default_nettype none
module vn1d_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_vld,
    input  vn1d_pkg::t_div_req      i_req,
    input  wire logic [30:0]        i_period,
    output vn1d_pkg::t_div_res      o_res
);
    localparam int N = vn1d_pkg::A_W;

    typedef struct packed {
        logic [30:0]  rem;
        logic [N-1:0] aq;
    } t_dstep;

    logic         r_vld [N];
    logic         r_neg [N];
    logic [30:0]  r_rem [N];
    logic [N-1:0] r_aq  [N];   // dividend bits shift out, quotient bits shift in

    function automatic t_dstep div_step(input logic [30:0] rem, input logic [N-1:0] aq,
                                        input logic [30:0] p);
        logic [31:0] trial;
        logic        ge;
        t_dstep      o;
        trial = {rem, aq[N-1]};
        ge    = (trial >= {1'b0, p});
        o.rem = ge ? 31'(trial - {1'b0, p}) : trial[30:0];
        o.aq  = {aq[N-2:0], ge};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) r_vld[j] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < N; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg[0] <= i_req.neg;
            {r_rem[0], r_aq[0]} <= div_step('0, i_req.mag, i_period);
            for (int j = 1; j < N; j++) begin
                r_neg[j] <= r_neg[j-1];
                {r_rem[j], r_aq[j]} <= div_step(r_rem[j-1], r_aq[j-1], i_period);
            end
        end
    end

    assign o_res.vld = r_vld[N-1];
    assign o_res.neg = r_neg[N-1];
    assign o_res.quo = r_aq[N-1];
endmodule
`default_nettype wire

// File: hw/rtl/vn1d_shape.sv
`default_nettype none
module vn1d_shape (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  vn1d_pkg::t_div_res      i_res,
    input  vn1d_pkg::t_cfg          i_cfg,
    output logic                    o_vld,
    output logic [31:0]             o_value
);
    localparam int F = vn1d_pkg::FRAC_BITS;

    logic [7:0] r_v;

    logic [31:0] r1_n0, r1_n1;
    logic [F-1:0] r1_f;
    logic [31:0] r2_t0, r2_t1, r2_n0, r2_n1;
    logic [29:0] r2_f30, r2_f2;
    logic [31:0] r3_u0, r3_u1, r3_n0, r3_n1;
    logic [30:0] r3_w;
    logic [31:0] r4_v0, r4_v1;
    logic [30:0] r4_w;
    logic signed [63:0] r5_prod;
    logic [31:0] r5_v0;
    logic signed [33:0] r6_e;
    logic signed [67:0] r7_p;
    logic [31:0] r8_res;

    logic        s_ovf;
    logic [31:0] s_c, s_k0, s_k1, s_h0, s_h1, s_m;
    logic [29:0] s_f30;
    logic [59:0] s_fsq;
    logic [61:0] s_wp;
    logic signed [32:0] s_dv;
    logic signed [33:0] s_v, s_d;
    logic signed [67:0] s_sum;
    logic signed [32:0] s_mid;

    always_comb begin
        s_ovf = |i_res.quo[vn1d_pkg::A_W-1:31];
        if (s_ovf) s_c = i_res.neg ? vn1d_pkg::S32_MIN : vn1d_pkg::S32_MAX;
        else       s_c = i_res.neg ? ~i_res.quo[31:0] : i_res.quo[31:0];
        s_k0  = {{F{s_c[31]}}, s_c[31:F]};
        s_k1  = s_k0 + 32'd1;
        s_f30 = {r1_f, {(30-F){1'b0}}};
        s_fsq = s_f30 * s_f30;
        s_m   = vn1d_pkg::THREE30 - {1'b0, r2_f30, 1'b0};
        s_wp  = r2_f2 * s_m;
        s_h0  = r3_n0 * r3_u0 + vn1d_pkg::HASH_OFF;
        s_h1  = r3_n1 * r3_u1 + vn1d_pkg::HASH_OFF;
        s_dv  = $signed({r4_v1[31], r4_v1}) - $signed({r4_v0[31], r4_v0});
        s_v   = $signed({{2{r5_v0[31]}}, r5_v0}) + $signed(r5_prod[63:30]);
        s_d   = $signed({{2{i_cfg.max_value[31]}}, i_cfg.max_value}) -
                $signed({{2{i_cfg.min_value[31]}}, i_cfg.min_value});
        s_sum = $signed({{36{i_cfg.min_value[31]}}, i_cfg.min_value}) + (r7_p >>> 31);
        s_mid = ($signed({i_cfg.min_value[31], i_cfg.min_value}) +
                 $signed({i_cfg.max_value[31], i_cfg.max_value})) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[6:0], i_res.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // lattice index, neighbour and fraction
            r1_n0 <= (s_k0 << 13) ^ s_k0;
            r1_n1 <= (s_k1 << 13) ^ s_k1;
            r1_f  <= s_c[F-1:0];
            // hash squares; fraction squared
            r2_t0  <= r1_n0 * r1_n0;
            r2_t1  <= r1_n1 * r1_n1;
            r2_n0  <= r1_n0;
            r2_n1  <= r1_n1;
            r2_f30 <= s_f30;
            r2_f2  <= s_fsq[59:30];
            // polynomial step; smoothstep weight
            r3_u0 <= r2_t0 * vn1d_pkg::HASH_MUL + vn1d_pkg::HASH_ADD;
            r3_u1 <= r2_t1 * vn1d_pkg::HASH_MUL + vn1d_pkg::HASH_ADD;
            r3_n0 <= r2_n0;
            r3_n1 <= r2_n1;
            r3_w  <= s_wp[60:30];
            // lattice values in Q2.30
            r4_v0 <= vn1d_pkg::ONE30 - {1'b0, s_h0[30:0]};
            r4_v1 <= vn1d_pkg::ONE30 - {1'b0, s_h1[30:0]};
            r4_w  <= r3_w;
            // blend: v0 + (v1-v0)*w
            r5_prod <= 64'(s_dv) * $signed({33'd0, r4_w});
            r5_v0   <= r4_v0;
            r6_e    <= s_v + $signed({2'b0, vn1d_pkg::ONE30});
            r7_p    <= 68'(s_d) * 68'(r6_e);
            if (i_cfg.period_length == '0)       r8_res <= s_mid[31:0];
            else if (s_sum > $signed(68'sh7FFF_FFFF))  r8_res <= vn1d_pkg::S32_MAX;
            else if (s_sum < -$signed(68'sh8000_0000)) r8_res <= vn1d_pkg::S32_MIN;
            else                                  r8_res <= s_sum[31:0];
        end
    end

    assign o_vld   = r_v[7];
    assign o_value = r8_res;
endmodule
`default_nettype wire
